[rtl/box_signed_distance_top_assert.svh]
// Assertion macros shared by the box distance RTL.
// Each macro takes a label, clock, active-low reset, antecedent,
// consequent and message.
`ifndef BOX_SIGNED_DISTANCE_TOP_ASSERT_SVH
`define BOX_SIGNED_DISTANCE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bsd_pkg.sv]
// ----------------------------------------------------------------------------
// bsd_pkg
// Register map and fixed constants of the box signed distance block.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int NUM_AXES  = 3;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_BOX_LOW_X  = 3'd0;
    localparam t_cfg_idx REG_BOX_LOW_Y  = 3'd1;
    localparam t_cfg_idx REG_BOX_LOW_Z  = 3'd2;
    localparam t_cfg_idx REG_BOX_HIGH_X = 3'd3;
    localparam t_cfg_idx REG_BOX_HIGH_Y = 3'd4;
    localparam t_cfg_idx REG_BOX_HIGH_Z = 3'd5;

endpackage

[rtl/bsd_axis_term.sv]
// ----------------------------------------------------------------------------
// bsd_axis_term
// Two-stage per-axis term: D = |2p - low - high| - (high - low), exact.
// ----------------------------------------------------------------------------
module bsd_axis_term #(
    parameter int COORD_W = 32
) (
    input  logic               i_clk,
    input  logic [COORD_W-1:0] i_point,
    input  logic [COORD_W-1:0] i_low,
    input  logic [COORD_W-1:0] i_high,
    output logic [COORD_W+2:0] o_term
);

    // stage 1: doubled offset from center and edge length
    logic [COORD_W+1:0] n_off;
    logic [COORD_W:0]   n_span;
    logic [COORD_W+1:0] r_off;
    logic [COORD_W:0]   r_span;

    assign n_off  = {i_point[COORD_W-1], i_point, 1'b0}
                  - {{2{i_low[COORD_W-1]}}, i_low}
                  - {{2{i_high[COORD_W-1]}}, i_high};
    assign n_span = {i_high[COORD_W-1], i_high} - {i_low[COORD_W-1], i_low};

    always_ff @(posedge i_clk) begin
        r_off  <= n_off;
        r_span <= n_span;
    end

    // stage 2: magnitude minus edge
    logic [COORD_W+1:0] n_mag;
    logic [COORD_W+2:0] n_term;
    logic [COORD_W+2:0] r_term;

    assign n_mag  = r_off[COORD_W+1] ? (~r_off + 1'b1) : r_off;
    assign n_term = {1'b0, n_mag} - {{2{r_span[COORD_W]}}, r_span};

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
    end

    assign o_term = r_term;

endmodule

[rtl/bsd_square.sv]
// ----------------------------------------------------------------------------
// bsd_square
// Two-stage square of the positive part of a signed term, built from three
// half-width partial products.
// ----------------------------------------------------------------------------
module bsd_square #(
    parameter int TERM_W = 35
) (
    input  logic                    i_clk,
    input  logic [TERM_W-1:0]       i_term,
    output logic [2*TERM_W-3:0]     o_square
);

    localparam int MAG_W = TERM_W - 1;
    localparam int LO_W  = (MAG_W + 1) / 2;
    localparam int HI_W  = MAG_W - LO_W;
    localparam int SQ_W  = 2 * MAG_W;

    logic [MAG_W-1:0] w_pos;
    logic [HI_W-1:0]  w_hi;
    logic [LO_W-1:0]  w_lo;

    // negative or zero terms contribute nothing
    assign w_pos = (!i_term[TERM_W-1] && (|i_term)) ? i_term[MAG_W-1:0] : '0;
    assign w_hi  = w_pos[MAG_W-1:LO_W];
    assign w_lo  = w_pos[LO_W-1:0];

    logic [2*HI_W-1:0]    r_hh;
    logic [HI_W+LO_W-1:0] r_hl;
    logic [2*LO_W-1:0]    r_ll;

    always_ff @(posedge i_clk) begin
        r_hh <= w_hi * w_hi;
        r_hl <= w_hi * w_lo;
        r_ll <= w_lo * w_lo;
    end

    // (h*2^L + l)^2 = h^2*2^2L + 2hl*2^L + l^2
    logic [SQ_W-1:0] n_square;
    logic [SQ_W-1:0] r_square;

    assign n_square = {r_hh, {(2*LO_W){1'b0}}}
                    + {{(HI_W-1){1'b0}}, r_hl, {(LO_W+1){1'b0}}}
                    + {{(2*HI_W){1'b0}}, r_ll};

    always_ff @(posedge i_clk) begin
        r_square <= n_square;
    end

    assign o_square = r_square;

endmodule

[rtl/bsd_sqrt.sv]
// ----------------------------------------------------------------------------
// bsd_sqrt
// Fully pipelined integer square root, one root bit per stage, with a
// sideband word carried alongside.
// ----------------------------------------------------------------------------
`include "box_signed_distance_top_assert.svh"

module bsd_sqrt #(
    parameter int ROOT_W = 35,
    parameter int SIDE_W = 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_radicand,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [ROOT_W-1:0] r_valid;
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W-1];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    genvar k;
    for (k = 0; k < ROOT_W; k++) begin : g_stage
        logic              w_vld_in;
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [RAD_W-1:0]  w_rad_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [REM_W-1:0]  w_rem_sh;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;

        if (k == 0) begin : g_head
            assign w_vld_in  = i_valid;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_radicand;
            assign w_side_in = i_side;
        end else begin : g_link
            assign w_vld_in  = r_valid[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rad_in  = r_rad[k-1];
            assign w_side_in = r_side[k-1];
        end

        // bring down the next bit pair, try root*4+1
        assign w_rem_sh = {w_rem_in[ROOT_W-1:0], w_rad_in[RAD_W-1 -: 2]};
        assign w_trial  = {w_root_in, 2'b01};
        assign w_ge     = (w_rem_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root[k] <= {w_root_in[ROOT_W-2:0], w_ge};
            r_side[k] <= w_side_in;
        end

        if (k < ROOT_W - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                r_rad[k] <= {w_rad_in[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

    // remainder of a floor root never exceeds twice the root
    `BSD_ASSERT_SAME(a_sqrt_rem_bound, i_clk, i_rst_n, o_valid,
        r_rem[ROOT_W-1] <= {1'b0, o_root, 1'b0}, "sqrt remainder out of bound")
    `BSD_ASSERT_SAME(a_sqrt_latency, i_clk, i_rst_n, o_valid,
        $past(i_valid, ROOT_W), "sqrt output without matching input")

endmodule

[rtl/box_signed_distance_top.sv]
// ----------------------------------------------------------------------------
// box_signed_distance_top
// Signed distance from a fixed-point 3D point to an axis-aligned box.
// ----------------------------------------------------------------------------
// Usage:
//   Box corners are written through i_cfg_we / i_cfg_idx / i_cfg_data
//   (low x,y,z at 0..2, high x,y,z at 3..5, other indexes ignored), only
//   while no transaction is in flight. A write takes effect at the edge.
//   A point transaction is accepted at an edge where start is high and
//   busy is low. busy is low every cycle except the first one after reset,
//   so one point per cycle is sustained.
//   Each result shows on o_distance / o_saturated for exactly one cycle
//   with o_valid high, after passing through 5 front stages (offset, term,
//   partial products, squares, sum), one stage per root bit in the
//   square-root pipe (COORD_WIDTH + 3 of them), and the rounding/saturation
//   output register.
//   There is no back-pressure: the receiver must take every result.
//   Reset (synchronous, active low) clears the corners to zero and drops
//   every transaction still in the pipe.
//   Results keep the Q format of the inputs; saturation only ever happens
//   on the outside branch, clamping to the largest positive value.
// ----------------------------------------------------------------------------
`include "box_signed_distance_top_assert.svh"

module box_signed_distance_top
    import bsd_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_idx,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,

    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    input  logic [COORD_WIDTH-1:0] i_point_z,

    output logic                   o_valid,
    output logic [COORD_WIDTH-1:0] o_distance,
    output logic                   o_saturated
);

    localparam int W      = COORD_WIDTH;
    localparam int TERM_W = W + 3;          // exact doubled per-axis term
    localparam int SQ_W   = 2 * (TERM_W - 1);
    localparam int ROOT_W = W + 3;
    localparam int SUM_W  = 2 * ROOT_W;     // holds three squares
    localparam int SIDE_W = W + 1;          // {outside flag, inside result}
    localparam int LAT    = W + 9;

    localparam logic [W-1:0]      DIST_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [ROOT_W-1:0] RND_MAX  = {{(ROOT_W-W+1){1'b0}}, {(W-1){1'b1}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [W-1:0] r_box_low  [NUM_AXES];
    logic [W-1:0] r_box_high [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_box_low[a]  <= '0;
                r_box_high[a] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOX_LOW_X:  r_box_low[0]  <= i_cfg_data;
                REG_BOX_LOW_Y:  r_box_low[1]  <= i_cfg_data;
                REG_BOX_LOW_Z:  r_box_low[2]  <= i_cfg_data;
                REG_BOX_HIGH_X: r_box_high[0] <= i_cfg_data;
                REG_BOX_HIGH_Y: r_box_high[1] <= i_cfg_data;
                REG_BOX_HIGH_Z: r_box_high[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input handshake: busy only for the cycle right after reset
    // ------------------------------------------------------------------
    logic r_busy;
    logic w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    // valid bits for front stages 1..5
    logic [4:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], w_accept};
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-2: per-axis doubled term D = 2d
    // Stages 3-4: squares of positive terms
    // ------------------------------------------------------------------
    logic [W-1:0]      w_point  [NUM_AXES];
    logic [TERM_W-1:0] w_term   [NUM_AXES];
    logic [SQ_W-1:0]   w_square [NUM_AXES];

    assign w_point[0] = i_point_x;
    assign w_point[1] = i_point_y;
    assign w_point[2] = i_point_z;

    genvar g;
    for (g = 0; g < NUM_AXES; g++) begin : g_axis
        bsd_axis_term #(
            .COORD_W (W)
        ) u_term (
            .i_clk   (i_clk),
            .i_point (w_point[g]),
            .i_low   (r_box_low[g]),
            .i_high  (r_box_high[g]),
            .o_term  (w_term[g])
        );

        bsd_square #(
            .TERM_W   (TERM_W)
        ) u_square (
            .i_clk    (i_clk),
            .i_term   (w_term[g]),
            .o_square (w_square[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 3: largest term (first axis wins ties, same value anyway)
    // ------------------------------------------------------------------
    logic [TERM_W-1:0] w_max01;
    logic [TERM_W-1:0] n_max;
    logic [TERM_W-1:0] r_max;

    assign w_max01 = ($signed(w_term[1]) > $signed(w_term[0])) ? w_term[1] : w_term[0];
    assign n_max   = ($signed(w_term[2]) > $signed(w_max01))   ? w_term[2] : w_max01;

    always_ff @(posedge i_clk) begin
        r_max <= n_max;
    end

    // ------------------------------------------------------------------
    // Stage 4: outside flag and inside result -floor(-D/2)
    // ------------------------------------------------------------------
    logic              n_outside;
    logic [TERM_W-1:0] w_neg_max;
    logic [TERM_W-1:0] w_half;
    logic [TERM_W-1:0] w_inside_full;
    logic              r_outside;
    logic [W-1:0]      r_inside;

    assign n_outside     = !r_max[TERM_W-1] && (|r_max);
    assign w_neg_max     = ~r_max + 1'b1;
    assign w_half        = {1'b0, w_neg_max[TERM_W-1:1]};
    assign w_inside_full = ~w_half + 1'b1;

    always_ff @(posedge i_clk) begin
        r_outside <= n_outside;
        r_inside  <= w_inside_full[W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 5: sum of squares
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  r_sum;
    logic [SIDE_W-1:0] r_side;

    always_ff @(posedge i_clk) begin
        r_sum  <= {2'b00, w_square[0]} + {2'b00, w_square[1]} + {2'b00, w_square[2]};
        r_side <= {r_outside, r_inside};
    end

    // ------------------------------------------------------------------
    // Square-root pipe, one root bit per stage
    // ------------------------------------------------------------------
    logic              w_sq_valid;
    logic [ROOT_W-1:0] w_root;
    logic [SIDE_W-1:0] w_sq_side;

    bsd_sqrt #(
        .ROOT_W     (ROOT_W),
        .SIDE_W     (SIDE_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_vld[4]),
        .i_radicand (r_sum),
        .i_side     (r_side),
        .o_valid    (w_sq_valid),
        .o_root     (w_root),
        .o_side     (w_sq_side)
    );

    // ------------------------------------------------------------------
    // Output stage: halve with round-half-up, saturate, pick branch
    // ------------------------------------------------------------------
    logic [ROOT_W:0]   w_rnd_full;
    logic [ROOT_W-1:0] w_rnd;
    logic              w_over;
    logic [W-1:0]      n_dist;
    logic              n_sat;

    assign w_rnd_full = {1'b0, w_root} + 1'b1;
    assign w_rnd      = w_rnd_full[ROOT_W:1];
    assign w_over     = (w_rnd > RND_MAX);

    always_comb begin
        if (w_sq_side[W]) begin
            n_dist = w_over ? DIST_MAX : w_rnd[W-1:0];
            n_sat  = w_over;
        end else begin
            n_dist = w_sq_side[W-1:0];
            n_sat  = 1'b0;
        end
    end

    logic         r_valid;
    logic         r_sat;
    logic [W-1:0] r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            r_valid <= w_sq_valid;
            r_sat   <= w_sq_valid && n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
    end

    assign o_valid     = r_valid;
    assign o_distance  = r_dist;
    assign o_saturated = r_sat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BSD_ASSERT_SAME(a_top_latency, i_clk, i_rst_n, o_valid,
        $past(w_accept, LAT), "result without a transaction accepted LAT cycles earlier")
    `BSD_ASSERT_SAME(a_top_sat_value, i_clk, i_rst_n, o_saturated,
        o_valid && (o_distance == DIST_MAX), "saturated result not clamped to maximum")
    `BSD_ASSERT_NEXT(a_top_inside_no_sat, i_clk, i_rst_n, w_sq_valid && !w_sq_side[W],
        o_valid && !o_saturated, "inside result flagged as saturated")

endmodule
